@@ rtl/idq_pkg.sv @@
package idq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND_TAIL = 3'd0,
        MODE_INSERT_HEAD = 3'd1,
        MODE_TAKE_HEAD   = 3'd2,
        MODE_TAKE_TAIL   = 3'd3,
        MODE_REMOVE_AT   = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic ins_tail;
        logic ins_head;
        logic del;
    } cell_cmd_t;

endpackage

@@ rtl/idq_cell.sv @@
module idq_cell
    import idq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int PW  = 4
)
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic [CW-1:0]            fill,
    input  logic [PW-1:0]            rm_pos,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] prev_data,
    input  logic signed [DATA_W-1:0] next_data,
    output logic signed [DATA_W-1:0] data,
    output logic signed [DATA_W-1:0] tap
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [PW-1:0] IDX_P = PW'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins_tail && IDX_C == fill)
        begin
            data_next = value;
        end
        else if (cmd.ins_head)
        begin
            if (IDX == 0)
            begin
                data_next = value;
            end
            else if (IDX_C <= fill)
            begin
                data_next = prev_data;
            end
        end
        else if (cmd.del && IDX_P >= rm_pos)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (cmd.del && IDX_P == rm_pos) ? data_reg : '0;

endmodule

@@ rtl/indexed_deque_store.sv @@
// channel   | handshake              | fields
// request   | start high, busy low   | mode, value, position
// result    | done high, one cycle   | status, taken_value, occupancy
// one item per cycle: every operation updates the whole row of cells at once
// the result appears on the cycle after the request is taken
// busy never rises, so a request can be taken on every cycle
// reset clears the count and the result strobe; cell contents are not reset
// the receiver cannot stall; each result is shown for exactly one cycle
module indexed_deque_store
    import idq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [MODE_W-1:0]             mode,
    input  logic signed [DATA_W-1:0]      value,
    input  logic [$clog2(DEPTH)-1:0]      position,
    output logic                          done,
    output logic [STATUS_W-1:0]           status,
    output logic signed [DATA_W-1:0]      taken_value,
    output logic [$clog2(DEPTH+1)-1:0]    occupancy
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    logic [CW-1:0]            fill_reg;
    logic [CW-1:0]            fill_next;
    logic                     done_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [DATA_W-1:0] taken_reg;
    logic signed [DATA_W-1:0] taken_next;

    cell_cmd_t                cmd;
    logic [PW-1:0]            rm_pos;
    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] cell_tap  [DEPTH];
    logic signed [DATA_W-1:0] tap_or;

    assign accept   = start && !busy;
    assign busy     = 1'b0;
    assign is_full  = (fill_reg == FULL_C);
    assign is_empty = (fill_reg == '0);

    always_comb
    begin
        cmd         = '0;
        rm_pos      = '0;
        fill_next   = fill_reg;
        status_next = ST_DONE;
        case (mode_t'(mode))
            MODE_APPEND_TAIL:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.ins_tail = accept;
                    fill_next    = fill_reg + 1'b1;
                end
            end
            MODE_INSERT_HEAD:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.ins_head = accept;
                    fill_next    = fill_reg + 1'b1;
                end
            end
            MODE_TAKE_HEAD:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.del   = accept;
                    fill_next = fill_reg - 1'b1;
                end
            end
            MODE_TAKE_TAIL:
            begin
                rm_pos = PW'(fill_reg - 1'b1);
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.del   = accept;
                    fill_next = fill_reg - 1'b1;
                end
            end
            MODE_REMOVE_AT:
            begin
                rm_pos = position;
                if (CW'(position) >= fill_reg)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.del   = accept;
                    fill_next = fill_reg - 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev_d;
        logic signed [DATA_W-1:0] next_d;

        if (k == 0)
        begin : g_first
            assign prev_d = value;
        end
        else
        begin : g_mid
            assign prev_d = cell_data[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign next_d = cell_data[k];
        end
        else
        begin : g_inner
            assign next_d = cell_data[k+1];
        end

        idq_cell #(
            .IDX (k),
            .CW  (CW),
            .PW  (PW)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .fill      (fill_reg),
            .rm_pos    (rm_pos),
            .value     (value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[k]),
            .tap       (cell_tap[k])
        );
    end

    always_comb
    begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            tap_or = tap_or | cell_tap[k];
        end
        taken_next = tap_or;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            taken_reg  <= taken_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign taken_value = taken_reg;
    assign occupancy   = fill_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_C)
        else $error("count above depth");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (occupancy == FULL_C && taken_value == '0))
        else $error("full refusal with wrong count or value");

    a_empty_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status_next == ST_EMPTY) |=> (fill_reg == $past(fill_reg)))
        else $error("refused take changed the count");

    a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(fill_reg))
        else $error("count moved without a request");

endmodule
